FILE: hw/rtl/tend_pkg.sv
// ----------------------------------------------------------------------------
// tend_pkg: shared types and helpers for the text encoding / newline detector
// Transaction structs, encoding and newline codes, and the per-byte scan
// functions used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package tend_pkg;

  localparam int RUN_DEPTH = 4;
  localparam int RUN_CNT_W = $clog2(RUN_DEPTH + 1);

  typedef enum logic [2:0] {
    TXT_UNKNOWN     = 3'd0,
    TXT_UTF8        = 3'd1,
    TXT_UTF8_MARKED = 3'd2,
    TXT_UTF16_LE    = 3'd3,
    TXT_UTF16_BE    = 3'd4,
    TXT_LEGACY      = 3'd5
  } enc_t;

  typedef enum logic [1:0] {
    NL_UNKNOWN = 2'd0,
    NL_LF      = 2'd1,
    NL_CRLF    = 2'd2,
    NL_CR      = 2'd3
  } nl_t;

  localparam logic [7:0]  MARK_EF  = 8'hEF;
  localparam logic [7:0]  MARK_BB  = 8'hBB;
  localparam logic [7:0]  MARK_BF  = 8'hBF;
  localparam logic [7:0]  MARK_FF  = 8'hFF;
  localparam logic [7:0]  MARK_FE  = 8'hFE;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [15:0] CH_LF    = 16'h000A;
  localparam logic [15:0] CH_CR    = 16'h000D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] text_unit;
    logic [2:0]  encoding_code;
    logic [1:0]  newline_code;
    logic        last_of_run;
  } out_item_t;

  // Scan state that every text byte or unit walks through.
  typedef struct packed {
    enc_t       enc;
    logic [1:0] cont;
    nl_t        nl;
    logic       pcr;
  } scan_t;

  function automatic logic [7:0] clean_byte(logic [7:0] b);
    return (b == 8'h00) ? CH_SPACE : b;
  endfunction

  function automatic logic is_mark_lead(logic [7:0] b);
    return (b == MARK_FE) || (b == MARK_FF) || (b == MARK_EF);
  endfunction

  function automatic scan_t watch_newline(scan_t s, logic [15:0] u);
    scan_t r;
    r = s;
    if (s.nl == NL_UNKNOWN) begin
      if (s.pcr) begin
        r.nl  = (u == CH_LF) ? NL_CRLF : NL_CR;
        r.pcr = 1'b0;
      end else if (u == CH_LF) begin
        r.nl = NL_LF;
      end else if (u == CH_CR) begin
        r.pcr = 1'b1;
      end
    end
    return r;
  endfunction

  // UTF-8 lead/continuation check; four-byte leads need bit 3 clear.
  function automatic scan_t check_utf8(scan_t s, logic [7:0] b);
    scan_t r;
    r = s;
    if (b[7]) begin
      if (b[6]) begin
        if (s.cont != 2'd0) begin
          r.enc = TXT_LEGACY;
        end else if (!b[5]) begin
          r.cont = 2'd1;
        end else if (!b[4]) begin
          r.cont = 2'd2;
        end else if (!b[3]) begin
          r.cont = 2'd3;
        end else begin
          r.enc = TXT_LEGACY;
        end
      end else if (s.cont != 2'd0) begin
        r.cont = s.cont - 2'd1;
      end else begin
        r.enc = TXT_LEGACY;
      end
    end else if (s.cont != 2'd0) begin
      r.enc = TXT_LEGACY;
    end
    return r;
  endfunction

  function automatic scan_t byte_scan(scan_t s, logic [7:0] b);
    scan_t      r;
    logic [7:0] c;
    c = clean_byte(b);
    r = s;
    if (r.enc == TXT_UTF8) begin
      r = check_utf8(r, c);
    end
    return watch_newline(r, {8'h00, c});
  endfunction

  // Pair two bytes into a unit in value order; an all-zero unit becomes a space.
  function automatic logic [15:0] pair_unit(enc_t enc, logic [7:0] b0, logic [7:0] b1);
    if (b0 == 8'h00 && b1 == 8'h00) begin
      return {8'h00, CH_SPACE};
    end else if (enc == TXT_UTF16_BE) begin
      return {b0, b1};
    end
    return {b1, b0};
  endfunction

  function automatic out_item_t text_result(logic [15:0] u);
    out_item_t r;
    r = '0;
    r.text_unit = u;
    return r;
  endfunction

  function automatic out_item_t summary_result(enc_t enc, nl_t nl);
    out_item_t r;
    r = '0;
    r.item_kind     = 1'b1;
    r.encoding_code = enc;
    r.newline_code  = nl;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/text_encoding_newline_detector_core.sv
// ----------------------------------------------------------------------------
// text_encoding_newline_detector_core
// Strips a byte-order mark, cleans text bytes or UTF-16 units, validates
// UTF-8, tracks the first newline kind and reports a per-file summary.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (byte_valid / byte_stall / byte_item) carries one file byte
//   per transaction, with has_byte = 0 for an empty-file end marker and
//   end_of_file = 1 on the final transaction of a file.
//   Output channel (unit_valid / unit_stall / unit_item) carries 0 to 4
//   result transactions per input: cleaned text units, then on end of file
//   one summary (item_kind = 1) with the encoding and newline codes.
//   last_of_run marks the final result caused by one input transaction.
// Timing:
//   An accepted byte lands in the input register and is processed from
//   there once the run buffer is empty or its last result leaves; its
//   results are registered into the run buffer and offered from its head.
//   The buffer drains one result per cycle while the receiver does not
//   stall, and plain text then runs at one byte per cycle. The input
//   register takes the next transaction while results wait.
// Reset: rst (synchronous) empties both registers and returns the scan to
//   the start of a file. A stalled receiver holds the run buffer; the
//   input side stalls once the input register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module text_encoding_newline_detector_core
  import tend_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      byte_valid,
  output logic           byte_stall,
  input  wire in_item_t  byte_item,
  output logic           unit_valid,
  input  wire logic      unit_stall,
  output out_item_t      unit_item
);

  // Input register
  logic      item_valid;
  in_item_t  item;

  // Run buffer: results of one input, head at entry 0
  out_item_t            run [RUN_DEPTH];
  out_item_t            run_next [RUN_DEPTH];
  logic [RUN_CNT_W-1:0] run_cnt;
  logic [RUN_CNT_W-1:0] fill;

  // File scan state
  scan_t      scan, scan_next;
  logic [1:0] hdr_count, hdr_count_next;
  logic [7:0] held0, held0_next;
  logic [7:0] held1, held1_next;
  logic [8:0] low_byte, low_byte_next;   // bit 8: first UTF-16 byte held

  logic byte_take;
  logic unit_take;
  logic load;

  assign unit_valid = (run_cnt != '0);
  assign unit_item  = run[0];
  assign unit_take  = unit_valid && !unit_stall;

  // Advance the input register when the run buffer is empty or its last
  // result leaves this cycle.
  assign load       = item_valid &&
                      ((run_cnt == '0) || ((run_cnt == RUN_CNT_W'(1)) && unit_take));
  assign byte_stall = item_valid && !load;
  assign byte_take  = byte_valid && !byte_stall;

  // Process one input transaction: mark detection, text cleaning, scan.
  always_comb begin
    scan_next      = scan;
    hdr_count_next = hdr_count;
    held0_next     = held0;
    held1_next     = held1;
    low_byte_next  = low_byte;
    fill           = '0;
    for (int i = 0; i < RUN_DEPTH; i++) begin
      run_next[i] = '0;
    end

    if (item.has_byte) begin
      if (scan.enc == TXT_UNKNOWN) begin
        if (hdr_count == 2'd0) begin
          if (is_mark_lead(item.data_byte)) begin
            held0_next     = item.data_byte;
            hdr_count_next = 2'd1;
          end else begin
            scan_next.enc = TXT_UTF8;
            run_next[fill[1:0]] = text_result({8'h00, clean_byte(item.data_byte)});
            scan_next = byte_scan(scan_next, item.data_byte);
            fill      = fill + 1'b1;
          end
        end else if (hdr_count == 2'd1) begin
          hdr_count_next = 2'd0;
          if (held0 == MARK_FE && item.data_byte == MARK_FF) begin
            scan_next.enc = TXT_UTF16_BE;
          end else if (held0 == MARK_FF && item.data_byte == MARK_FE) begin
            scan_next.enc = TXT_UTF16_LE;
          end else if (held0 == MARK_EF && item.data_byte == MARK_BB) begin
            held1_next     = item.data_byte;
            hdr_count_next = 2'd2;
          end else begin
            // Not a mark: release the held byte, then this one.
            scan_next.enc = TXT_UTF8;
            run_next[fill[1:0]] = text_result({8'h00, clean_byte(held0)});
            scan_next = byte_scan(scan_next, held0);
            fill      = fill + 1'b1;
            run_next[fill[1:0]] = text_result({8'h00, clean_byte(item.data_byte)});
            scan_next = byte_scan(scan_next, item.data_byte);
            fill      = fill + 1'b1;
          end
        end else begin
          hdr_count_next = 2'd0;
          if (held0 == MARK_EF && held1 == MARK_BB && item.data_byte == MARK_BF) begin
            scan_next.enc = TXT_UTF8_MARKED;
          end else begin
            scan_next.enc = TXT_UTF8;
            run_next[fill[1:0]] = text_result({8'h00, clean_byte(held0)});
            scan_next = byte_scan(scan_next, held0);
            fill      = fill + 1'b1;
            run_next[fill[1:0]] = text_result({8'h00, clean_byte(held1)});
            scan_next = byte_scan(scan_next, held1);
            fill      = fill + 1'b1;
            run_next[fill[1:0]] = text_result({8'h00, clean_byte(item.data_byte)});
            scan_next = byte_scan(scan_next, item.data_byte);
            fill      = fill + 1'b1;
          end
        end
      end else if (scan.enc == TXT_UTF16_LE || scan.enc == TXT_UTF16_BE) begin
        if (low_byte[8]) begin
          run_next[fill[1:0]] =
            text_result(pair_unit(scan.enc, low_byte[7:0], item.data_byte));
          scan_next = watch_newline(scan_next,
                                    pair_unit(scan.enc, low_byte[7:0], item.data_byte));
          fill          = fill + 1'b1;
          low_byte_next = '0;
        end else begin
          low_byte_next = {1'b1, item.data_byte};
        end
      end else begin
        run_next[fill[1:0]] = text_result({8'h00, clean_byte(item.data_byte)});
        scan_next = byte_scan(scan_next, item.data_byte);
        fill      = fill + 1'b1;
      end
    end

    if (item.end_of_file) begin
      // Flush an undecided mark as UTF-8 text.
      if (scan_next.enc == TXT_UNKNOWN && hdr_count_next != 2'd0) begin
        scan_next.enc = TXT_UTF8;
        run_next[fill[1:0]] = text_result({8'h00, clean_byte(held0_next)});
        scan_next = byte_scan(scan_next, held0_next);
        fill      = fill + 1'b1;
        if (hdr_count_next >= 2'd2) begin
          run_next[fill[1:0]] = text_result({8'h00, clean_byte(held1_next)});
          scan_next = byte_scan(scan_next, held1_next);
          fill      = fill + 1'b1;
        end
      end
      // Pair an odd trailing UTF-16 byte with zero.
      if (low_byte_next[8]) begin
        run_next[fill[1:0]] =
          text_result(pair_unit(scan_next.enc, low_byte_next[7:0], 8'h00));
        scan_next = watch_newline(scan_next,
                                  pair_unit(scan_next.enc, low_byte_next[7:0], 8'h00));
        fill      = fill + 1'b1;
      end
      if (scan_next.pcr && scan_next.nl == NL_UNKNOWN) begin
        scan_next.nl = NL_CR;
      end
      if (scan_next.enc == TXT_UTF8 && scan_next.cont != 2'd0) begin
        scan_next.enc = TXT_LEGACY;
      end
      run_next[fill[1:0]] = summary_result(scan_next.enc, scan_next.nl);
      fill = fill + 1'b1;
      // Start the next file from a clean state.
      scan_next      = '0;
      hdr_count_next = 2'd0;
      held0_next     = '0;
      held1_next     = '0;
      low_byte_next  = '0;
    end

    for (int i = 0; i < RUN_DEPTH; i++) begin
      run_next[i].last_of_run = (fill == RUN_CNT_W'(i + 1));
    end
  end

  // Input register: take a transaction whenever it is free or moving on.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (byte_take) begin
      item_valid <= 1'b1;
    end else if (load) begin
      item_valid <= 1'b0;
    end
    if (byte_take) begin
      item <= byte_item;
    end
  end

  // Scan state advances once per processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan      <= '0;
      hdr_count <= 2'd0;
      held0     <= '0;
      held1     <= '0;
      low_byte  <= '0;
    end else if (load) begin
      scan      <= scan_next;
      hdr_count <= hdr_count_next;
      held0     <= held0_next;
      held1     <= held1_next;
      low_byte  <= low_byte_next;
    end
  end

  // Run buffer: load a new run, or drop the head when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
    end else if (load) begin
      run_cnt <= fill;
    end else if (unit_take) begin
      run_cnt <= run_cnt - 1'b1;
    end
    if (load) begin
      for (int i = 0; i < RUN_DEPTH; i++) begin
        run[i] <= run_next[i];
      end
    end else if (unit_take) begin
      for (int i = 0; i < RUN_DEPTH - 1; i++) begin
        run[i] <= run[i+1];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_run_cnt_range: assert property (@(posedge clk) disable iff (rst)
    run_cnt <= RUN_CNT_W'(RUN_DEPTH))
    else $error("run buffer count out of range");

  a_last_matches_cnt: assert property (@(posedge clk) disable iff (rst)
    unit_valid |-> (unit_item.last_of_run == (run_cnt == RUN_CNT_W'(1))))
    else $error("last_of_run does not mark the final result of a run");

  a_summary_is_last: assert property (@(posedge clk) disable iff (rst)
    (unit_valid && unit_item.item_kind) |-> unit_item.last_of_run)
    else $error("summary is not the last result of its run");

  a_text_has_no_codes: assert property (@(posedge clk) disable iff (rst)
    (unit_valid && !unit_item.item_kind) |->
      (unit_item.encoding_code == TXT_UNKNOWN && unit_item.newline_code == NL_UNKNOWN))
    else $error("text result carries encoding or newline code");

  a_eof_clears_scan: assert property (@(posedge clk) disable iff (rst)
    (load && item.end_of_file) |=>
      (scan == '0 && hdr_count == 2'd0 && !low_byte[8]))
    else $error("scan state not cleared after end of file");
`endif

endmodule

`default_nettype wire

FILE: tb/text_encoding_newline_detector_core_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_encoding_newline_detector_core_check
// Watches both channels of the detector. For every accepted byte transaction
// it works out the text units and file summary the block owes, and compares
// accepted result transactions against them in order, field by field.
// ----------------------------------------------------------------------------
module text_encoding_newline_detector_core_check
  import tend_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      byte_valid,
  input  wire logic      byte_stall,
  input  wire in_item_t  byte_item,
  input  wire logic      unit_valid,
  input  wire logic      unit_stall,
  input  wire out_item_t unit_item,
  output int             mismatch_count,
  output int             awaited_count
);

  // Per-file decode state.
  logic [1:0] mark_len;
  logic [7:0] mark_bytes [3];
  enc_t       file_enc;
  logic [1:0] cont_left;
  nl_t        first_nl;
  logic       cr_waiting;
  logic       half_held;
  logic [7:0] half_byte;

  out_item_t  expected_units [$];
  int         unit_index;

  task automatic restart_file();
    mark_len      = 2'd0;
    mark_bytes[0] = 8'h00;
    mark_bytes[1] = 8'h00;
    mark_bytes[2] = 8'h00;
    file_enc      = TXT_UNKNOWN;
    cont_left     = 2'd0;
    first_nl      = NL_UNKNOWN;
    cr_waiting    = 1'b0;
    half_held     = 1'b0;
    half_byte     = 8'h00;
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (mismatch_count < 200) begin
      $display("result %0d: %s is %0h, expected %0h", unit_index, what, got, want);
    end
    mismatch_count++;
  endtask

  // Only the first newline kind counts; a CR decides on its successor.
  task automatic note_newline(logic [15:0] u);
    if (first_nl == NL_UNKNOWN) begin
      if (cr_waiting) begin
        first_nl   = (u == CH_LF) ? NL_CRLF : NL_CR;
        cr_waiting = 1'b0;
      end else if (u == CH_LF) begin
        first_nl = NL_LF;
      end else if (u == CH_CR) begin
        cr_waiting = 1'b1;
      end
    end
  endtask

  task automatic push_text(logic [15:0] u);
    out_item_t r;
    r           = '0;
    r.text_unit = u;
    expected_units.push_back(r);
  endtask

  // Lead bytes 11110xxx take three continuations; 11111xxx is never legal.
  task automatic utf8_walk(logic [7:0] b);
    if (b[7]) begin
      if (b[6]) begin
        if (cont_left != 2'd0) begin
          file_enc = TXT_LEGACY;
        end else if (!b[5]) begin
          cont_left = 2'd1;
        end else if (!b[4]) begin
          cont_left = 2'd2;
        end else if (!b[3]) begin
          cont_left = 2'd3;
        end else begin
          file_enc = TXT_LEGACY;
        end
      end else if (cont_left != 2'd0) begin
        cont_left = cont_left - 2'd1;
      end else begin
        file_enc = TXT_LEGACY;
      end
    end else if (cont_left != 2'd0) begin
      file_enc = TXT_LEGACY;
    end
  endtask

  task automatic text_byte(logic [7:0] b);
    logic [7:0] c;
    c = (b == 8'h00) ? CH_SPACE : b;
    if (file_enc == TXT_UTF8) begin
      utf8_walk(c);
    end
    note_newline({8'h00, c});
    push_text({8'h00, c});
  endtask

  task automatic text_pair(logic [7:0] b0, logic [7:0] b1);
    logic [15:0] u;
    if (b0 == 8'h00 && b1 == 8'h00) begin
      u = {8'h00, CH_SPACE};
    end else if (file_enc == TXT_UTF16_BE) begin
      u = {b0, b1};
    end else begin
      u = {b1, b0};
    end
    note_newline(u);
    push_text(u);
  endtask

  // Byte-order mark search: BE, then LE, then the three-byte UTF-8 mark.
  task automatic mark_byte(logic [7:0] b);
    logic [7:0] h0;
    logic [7:0] h1;
    h0 = mark_bytes[0];
    h1 = mark_bytes[1];
    if (mark_len == 2'd0) begin
      if (b == MARK_FE || b == MARK_FF || b == MARK_EF) begin
        mark_bytes[0] = b;
        mark_len      = 2'd1;
      end else begin
        file_enc = TXT_UTF8;
        text_byte(b);
      end
    end else if (mark_len == 2'd1) begin
      mark_len = 2'd0;
      if (h0 == MARK_FE && b == MARK_FF) begin
        file_enc = TXT_UTF16_BE;
      end else if (h0 == MARK_FF && b == MARK_FE) begin
        file_enc = TXT_UTF16_LE;
      end else if (h0 == MARK_EF && b == MARK_BB) begin
        mark_bytes[1] = b;
        mark_len      = 2'd2;
      end else begin
        file_enc = TXT_UTF8;
        text_byte(h0);
        text_byte(b);
      end
    end else begin
      mark_len = 2'd0;
      if (h0 == MARK_EF && h1 == MARK_BB && b == MARK_BF) begin
        file_enc = TXT_UTF8_MARKED;
      end else begin
        mark_bytes[2] = b;
        file_enc      = TXT_UTF8;
        text_byte(h0);
        text_byte(h1);
        text_byte(b);
      end
    end
  endtask

  task automatic predict_units(in_item_t it);
    int        prior_size;
    int        i;
    out_item_t tail;
    prior_size = expected_units.size();
    if (it.has_byte) begin
      if (file_enc == TXT_UNKNOWN) begin
        mark_byte(it.data_byte);
      end else if (file_enc == TXT_UTF16_LE || file_enc == TXT_UTF16_BE) begin
        if (half_held) begin
          text_pair(half_byte, it.data_byte);
          half_held = 1'b0;
        end else begin
          half_held = 1'b1;
          half_byte = it.data_byte;
        end
      end else begin
        text_byte(it.data_byte);
      end
    end
    if (it.end_of_file) begin
      // Flush an undecided mark as plain UTF-8 text.
      if (file_enc == TXT_UNKNOWN && mark_len != 2'd0) begin
        file_enc = TXT_UTF8;
        for (i = 0; i < int'(mark_len); i++) begin
          text_byte(mark_bytes[i]);
        end
        mark_len = 2'd0;
      end
      if (half_held) begin
        text_pair(half_byte, 8'h00);
        half_held = 1'b0;
      end
      if (cr_waiting && first_nl == NL_UNKNOWN) begin
        first_nl = NL_CR;
      end
      if (file_enc == TXT_UTF8 && cont_left != 2'd0) begin
        file_enc = TXT_LEGACY;
      end
      tail               = '0;
      tail.item_kind     = 1'b1;
      tail.encoding_code = file_enc;
      tail.newline_code  = first_nl;
      expected_units.push_back(tail);
      restart_file();
    end
    if (expected_units.size() > prior_size) begin
      tail             = expected_units.pop_back();
      tail.last_of_run = 1'b1;
      expected_units.push_back(tail);
    end
  endtask

  task automatic compare_unit(out_item_t got);
    out_item_t want;
    if (expected_units.size() == 0) begin
      report_mismatch("unexpected result, text_unit", got.text_unit, 16'h0000);
    end else begin
      want = expected_units.pop_front();
      if (got.item_kind !== want.item_kind) begin
        report_mismatch("item_kind", 16'(got.item_kind), 16'(want.item_kind));
      end
      if (got.text_unit !== want.text_unit) begin
        report_mismatch("text_unit", got.text_unit, want.text_unit);
      end
      if (got.encoding_code !== want.encoding_code) begin
        report_mismatch("encoding_code", 16'(got.encoding_code),
                        16'(want.encoding_code));
      end
      if (got.newline_code !== want.newline_code) begin
        report_mismatch("newline_code", 16'(got.newline_code), 16'(want.newline_code));
      end
      if (got.last_of_run !== want.last_of_run) begin
        report_mismatch("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run));
      end
    end
    unit_index++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_file();
      expected_units.delete();
    end else begin
      if (byte_valid && !byte_stall) begin
        predict_units(byte_item);
      end
      if (unit_valid && !unit_stall) begin
        compare_unit(unit_item);
      end
    end
    awaited_count = expected_units.size();
  end

endmodule

FILE: tb/text_encoding_newline_detector_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_encoding_newline_detector_core_test
// Feeds whole files through the detector: a few hand-picked files around
// the byte-order mark and end-of-file corners, then random files of every
// encoding, clean and broken. The sender runs in bursts and the receiver
// stalls on its own pattern; a checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module text_encoding_newline_detector_core_test;
  import tend_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef enum logic [2:0] {
    FILE_UTF16LE,
    FILE_UTF16BE,
    FILE_UTF8_MARKED,
    FILE_UTF8_CLEAN,
    FILE_UTF8_BROKEN,
    FILE_NOISE,
    FILE_PARTIAL_MARK,
    FILE_EMPTY
  } file_style_t;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  in_item_t    byte_item;
  logic        unit_valid;
  logic        unit_stall;
  out_item_t   unit_item;

  int          mismatch_count;
  int          awaited_count;

  // Bytes of the file being sent, first byte at the front.
  logic [7:0]  file_bytes [$];
  int          burst_left;
  int          sent_count;

  stall_mode_t stall_mode;
  int          stall_span;
  int          stall_phase;

  text_encoding_newline_detector_core dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_item  (unit_item)
  );

  text_encoding_newline_detector_core_check unit_check (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .byte_item      (byte_item),
    .unit_valid     (unit_valid),
    .unit_stall     (unit_stall),
    .unit_item      (unit_item),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: switch between no stall, light and heavy random stall and a
  // fixed two-in-five pattern, each held for a random stretch of cycles.
  initial begin
    unit_stall  = 1'b0;
    stall_mode  = STALL_NONE;
    stall_span  = 0;
    stall_phase = 0;
    forever begin
      @(posedge clk);
      if (stall_span == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_span = $urandom_range(16, 200);
      end
      stall_span--;
      stall_phase = (stall_phase == 4) ? 0 : stall_phase + 1;
      case (stall_mode)
        STALL_NONE:  unit_stall <= 1'b0;
        STALL_LIGHT: unit_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: unit_stall <= ($urandom_range(0, 9) < 7);
        default:     unit_stall <= (stall_phase < 2);
      endcase
    end
  end

  // Give up on a hung block well past the slowest legal run.
  initial begin
    #1000000;
    $display("text_encoding_newline_detector_core: mismatch");
    $finish;
  end

  function automatic logic [7:0] rand_byte(int lo, int hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  function automatic in_item_t make_item(logic [7:0] b, logic has, logic eof);
    in_item_t it;
    it.data_byte   = b;
    it.has_byte    = has;
    it.end_of_file = eof;
    return it;
  endfunction

  // ASCII text, mostly printable, salted with newlines and nulls.
  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 9))
      0:       return CH_LF[7:0];
      1:       return CH_CR[7:0];
      2:       return 8'h00;
      3:       return rand_byte(0, 127);
      default: return rand_byte(8'h20, 8'h7E);
    endcase
  endfunction

  function automatic logic [15:0] utf16_unit();
    case ($urandom_range(0, 7))
      0:       return CH_LF;
      1:       return CH_CR;
      2:       return 16'h0000;
      3:       return {8'h00, text_char()};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic file_style_t pick_style();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2)  return FILE_UTF16LE;
    if (r < 4)  return FILE_UTF16BE;
    if (r < 6)  return FILE_UTF8_MARKED;
    if (r < 10) return FILE_UTF8_CLEAN;
    if (r < 12) return FILE_UTF8_BROKEN;
    if (r < 13) return FILE_NOISE;
    if (r < 15) return FILE_PARTIAL_MARK;
    return FILE_EMPTY;
  endfunction

  // Append one well-formed UTF-8 character; four-byte leads span F0..F7.
  task automatic push_utf8_char();
    int k;
    case ($urandom_range(0, 6))
      0: begin
        file_bytes.push_back(rand_byte(8'hC2, 8'hDF));
        k = 1;
      end
      1: begin
        file_bytes.push_back(rand_byte(8'hE0, 8'hEF));
        k = 2;
      end
      2: begin
        file_bytes.push_back(rand_byte(8'hF0, 8'hF7));
        k = 3;
      end
      default: begin
        file_bytes.push_back(text_char());
        k = 0;
      end
    endcase
    repeat (k) file_bytes.push_back(rand_byte(8'h80, 8'hBF));
  endtask

  task automatic build_file(file_style_t style);
    int          n;
    int          pos;
    logic [15:0] u;
    file_bytes.delete();
    case (style)
      FILE_UTF16LE, FILE_UTF16BE: begin
        if (style == FILE_UTF16LE) begin
          file_bytes.push_back(MARK_FF);
          file_bytes.push_back(MARK_FE);
        end else begin
          file_bytes.push_back(MARK_FE);
          file_bytes.push_back(MARK_FF);
        end
        n = $urandom_range(0, 8);
        repeat (n) begin
          u = utf16_unit();
          if (style == FILE_UTF16LE) begin
            file_bytes.push_back(u[7:0]);
            file_bytes.push_back(u[15:8]);
          end else begin
            file_bytes.push_back(u[15:8]);
            file_bytes.push_back(u[7:0]);
          end
        end
        // Leave an odd byte behind now and then.
        if ($urandom_range(0, 3) == 0) begin
          file_bytes.push_back(rand_byte(0, 255));
        end
      end
      FILE_UTF8_MARKED: begin
        file_bytes.push_back(MARK_EF);
        file_bytes.push_back(MARK_BB);
        file_bytes.push_back(MARK_BF);
        n = $urandom_range(0, 12);
        repeat (n) begin
          file_bytes.push_back($urandom_range(0, 1) ? text_char() : rand_byte(0, 255));
        end
      end
      FILE_UTF8_CLEAN, FILE_UTF8_BROKEN: begin
        n = $urandom_range(1, 10);
        repeat (n) push_utf8_char();
        if (style == FILE_UTF8_BROKEN) begin
          pos = $urandom_range(0, file_bytes.size());
          case ($urandom_range(0, 3))
            // Drop a lead byte at the end, so its character stays open.
            0:       file_bytes.push_back(rand_byte(8'hC0, 8'hF7));
            1:       file_bytes.insert(pos, rand_byte(8'h80, 8'hBF));
            2:       file_bytes.insert(pos, rand_byte(8'hF8, 8'hFF));
            default: file_bytes.insert(pos, text_char());
          endcase
        end
      end
      FILE_NOISE: begin
        n = $urandom_range(1, 12);
        repeat (n) file_bytes.push_back(rand_byte(0, 255));
      end
      FILE_PARTIAL_MARK: begin
        case ($urandom_range(0, 4))
          0: file_bytes.push_back(MARK_FE);
          1: file_bytes.push_back(MARK_FF);
          2: file_bytes.push_back(MARK_EF);
          3: begin
            file_bytes.push_back(MARK_EF);
            file_bytes.push_back(MARK_BB);
          end
          default: begin
            file_bytes.push_back(MARK_EF);
            file_bytes.push_back(MARK_BB);
            file_bytes.push_back(rand_byte(0, 255));
          end
        endcase
        if ($urandom_range(0, 1) == 0) begin
          file_bytes.push_back(rand_byte(0, 255));
        end
        n = $urandom_range(0, 5);
        repeat (n) file_bytes.push_back(text_char());
      end
      default: ;
    endcase
  endtask

  // Offer one transaction and hold it until accepted. Open a new burst when
  // the current one is used up, usually after a random gap.
  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        byte_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    burst_left--;
  endtask

  // Send the bytes of file_bytes as one file. Mark the end either on the
  // last byte or on a separate byte-less transaction; an empty file always
  // takes the separate one. Sprinkle in byte-less, non-final transactions
  // that the block must ignore.
  task automatic send_file(bit eof_on_last);
    int total;
    int i;
    total = file_bytes.size();
    for (i = 0; i < total; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        send_item(make_item(rand_byte(0, 255), 1'b0, 1'b0));
      end
      send_item(make_item(file_bytes[i], 1'b1, eof_on_last && (i == total - 1)));
      sent_count++;
    end
    if (!eof_on_last || total == 0) begin
      send_item(make_item(rand_byte(0, 255), 1'b0, 1'b1));
      sent_count++;
    end
  endtask

  initial begin
    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_item  = '0;
    burst_left = 0;
    sent_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed files. An ignored transaction first, then an empty file.
    send_item(make_item(8'hA5, 1'b0, 1'b0));
    file_bytes.delete();
    send_file(1'b1);
    // BE mark, CRLF, odd trailing byte paired with zero at the end.
    file_bytes = '{MARK_FE, MARK_FF, 8'h00, 8'h0D, 8'h00, 8'h0A, 8'h41};
    send_file(1'b1);
    // LE mark, lone CR right before end of file counts as CR.
    file_bytes = '{MARK_FF, MARK_FE, 8'h0D, 8'h00};
    send_file(1'b0);
    // UTF-8 mark: a stray continuation byte is not checked.
    file_bytes = '{MARK_EF, MARK_BB, MARK_BF, 8'h80};
    send_file(1'b1);
    // Broken three-byte mark flushed with the end: the widest run of results.
    file_bytes = '{MARK_EF, MARK_BB, 8'h0D};
    send_file(1'b1);
    // Two held mark bytes flushed at end of file leave a character open.
    file_bytes = '{MARK_EF, MARK_BB};
    send_file(1'b0);
    // One held byte flushed at end of file is an invalid lead.
    file_bytes = '{MARK_FF};
    send_file(1'b1);
    // Broken two-byte mark, then LF.
    file_bytes = '{MARK_FE, 8'h0A};
    send_file(1'b1);
    // Two-byte character, then a null turned into a space.
    file_bytes = '{8'hC3, 8'hA9, 8'h00};
    send_file(1'b1);

    // Random files until enough transactions have gone in.
    sent_count = 0;
    while (sent_count < 480) begin
      build_file(pick_style());
      send_file(1'($urandom_range(0, 1)));
    end
    byte_valid <= 1'b0;

    // Drain: wait for every owed result, then a few more cycles so a late
    // extra result still shows up.
    do @(posedge clk); while (awaited_count != 0);
    repeat (16) @(posedge clk);

    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("text_encoding_newline_detector_core: match");
    end else begin
      $display("text_encoding_newline_detector_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/tend_pkg.sv
hw/rtl/text_encoding_newline_detector_core.sv
tb/text_encoding_newline_detector_core_check.sv
tb/text_encoding_newline_detector_core_test.sv
